// ===== src/y2r_pkg.sv =====
`default_nettype none

package y2r_pkg;

    localparam int unsigned PixW  = 8;
    localparam int unsigned TermW = 27;
    localparam int unsigned SumW  = 28;
    localparam int unsigned FracBits = 16;

    localparam logic signed [19:0] K_LUMA     = 20'sd76284;
    localparam logic signed [19:0] K_CR_RED   = 20'sd104595;
    localparam logic signed [19:0] K_CR_GREEN = 20'sd53281;
    localparam logic signed [19:0] K_CB_GREEN = 20'sd25625;
    localparam logic signed [19:0] K_CB_BLUE  = 20'sd132252;
    localparam logic signed [8:0]  CHROMA_BIAS = 9'sd128;
    localparam logic signed [8:0]  LUMA_BIAS   = 9'sd16;
    localparam logic [7:0]         ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0]         PIX_MAX      = 8'd255;

    typedef enum logic [1:0] {
        POS_TOP_LEFT     = 2'd0,
        POS_TOP_RIGHT    = 2'd1,
        POS_BOTTOM_LEFT  = 2'd2,
        POS_BOTTOM_RIGHT = 2'd3
    } pix_pos_t;

    typedef enum logic {
        FMT_BGR24  = 1'b0,
        FMT_BGRA32 = 1'b1
    } out_fmt_t;

    // one 2x2 block with its chroma terms already worked out
    typedef struct packed {
        logic [3:0][PixW-1:0]    luma;
        logic signed [TermW-1:0] b_term;
        logic signed [TermW-1:0] g_term;
        logic signed [TermW-1:0] r_term;
    } blk_t;

    // floor shift by the fraction bits, then clamp to a byte
    function automatic logic [PixW-1:0] clamp_px(logic signed [SumW-1:0] s);
        logic signed [SumW-FracBits-1:0] t;
        logic [PixW-1:0] r;
        t = s[SumW-1:FracBits];
        if (t < 0)
            r = '0;
        else if (t > $signed({{(SumW-FracBits-PixW){1'b0}}, PIX_MAX}))
            r = PIX_MAX;
        else
            r = t[PixW-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/yuv420_to_rgb_block_converter_unit.sv =====
// Path: each block is registered by the front stage and held in the queue; its
// pixels then pass through the multiply stage and the output register, leaving
// one per cycle when the sink keeps up. The back-end pixel sequencer runs one luma
// multiply per cycle unless the multiply stage is held by a stalled output register.
// Reset: asynchronous, active low; clears all valid flags and pointers and sets
// output_format to 32-bit BGRA.
`default_nettype none

module yuv420_to_rgb_block_converter_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,        // output_format
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    // chroma_blue, chroma_red
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,     // blue, green, red, alpha
    output logic [1:0]       m_axis_tuser,     // pixel_position
    output logic             m_axis_tlast      // last_of_block
);

    logic          fmt_reg;
    logic          fr_valid;
    logic          fr_ready;
    y2r_pkg::blk_t fr_blk;
    logic          q_valid;
    logic          q_ready;
    y2r_pkg::blk_t q_blk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= y2r_pkg::FMT_BGRA32;
        else if (cfg_we)
            fmt_reg <= cfg_wdata;
    end

    y2r_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_blk   (fr_blk)
    );

    y2r_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_blk   (fr_blk),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_blk    (q_blk)
    );

    y2r_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .blk_valid     (q_valid),
        .blk_ready     (q_ready),
        .blk           (q_blk),
        .output_format (fmt_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (m_axis_tdata),
        .out_user      (m_axis_tuser),
        .out_last      (m_axis_tlast)
    );

    a_last_on_final_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == y2r_pkg::POS_BOTTOM_RIGHT)))
        else $error("tlast does not match final pixel position");

    a_alpha_follows_format: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:24] ==
            ((fmt_reg == y2r_pkg::FMT_BGRA32) ? y2r_pkg::ALPHA_OPAQUE : 8'd0)))
        else $error("alpha byte does not follow output format");

    a_pixel_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1 m_axis_tvalid
            |-> (m_axis_tuser == $past(m_axis_tuser) + 2'd1))
        else $error("pixel position skipped within a block");

endmodule

`default_nettype wire

// ===== src/y2r_front.sv =====
`default_nettype none

module y2r_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [47:0]        in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output y2r_pkg::blk_t           out_blk
);

    logic            valid_reg;
    y2r_pkg::blk_t   blk_reg;
    y2r_pkg::blk_t   blk_next;
    logic signed [8:0] cb;
    logic signed [8:0] cr;
    logic signed [y2r_pkg::TermW-1:0] cr_g;
    logic signed [y2r_pkg::TermW-1:0] cb_g;
    logic            accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cb = $signed({1'b0, in_data[39:32]}) - y2r_pkg::CHROMA_BIAS;
        cr = $signed({1'b0, in_data[47:40]}) - y2r_pkg::CHROMA_BIAS;
        cr_g = cr * y2r_pkg::K_CR_GREEN;
        cb_g = cb * y2r_pkg::K_CB_GREEN;
        blk_next.luma[0] = in_data[7:0];
        blk_next.luma[1] = in_data[15:8];
        blk_next.luma[2] = in_data[23:16];
        blk_next.luma[3] = in_data[31:24];
        blk_next.b_term  = cb * y2r_pkg::K_CB_BLUE;
        blk_next.g_term  = cr_g + cb_g;
        blk_next.r_term  = cr * y2r_pkg::K_CR_RED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            blk_reg <= blk_next;
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule

`default_nettype wire

// ===== src/y2r_queue.sv =====
`default_nettype none

module y2r_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire y2r_pkg::blk_t push_blk,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output y2r_pkg::blk_t      pop_blk
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    y2r_pkg::blk_t   mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != FullCnt);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_blk    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CntW'(1);
        else if (pop && !push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_blk;
    end

endmodule

`default_nettype wire

// ===== src/y2r_back.sv =====
`default_nettype none

module y2r_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          blk_valid,
    output logic               blk_ready,
    input  wire y2r_pkg::blk_t blk,
    input  wire logic          output_format,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [31:0]        out_data,
    output logic [1:0]         out_user,
    output logic               out_last
);

    localparam int unsigned TW = y2r_pkg::TermW;
    localparam int unsigned SW = y2r_pkg::SumW;

    logic [1:0]          pos_reg;
    logic                issue;
    logic                s1_ready;
    logic                o_ready;
    logic signed [8:0]   yd;

    // multiply stage
    logic                s1_valid_reg;
    logic [1:0]          s1_pos_reg;
    logic signed [TW-1:0] s1_y_reg;
    logic signed [TW-1:0] s1_b_reg;
    logic signed [TW-1:0] s1_g_reg;
    logic signed [TW-1:0] s1_r_reg;
    logic signed [TW-1:0] y_next;

    // output register
    logic                o_valid_reg;
    logic [7:0]          o_blue_reg;
    logic [7:0]          o_green_reg;
    logic [7:0]          o_red_reg;
    logic [1:0]          o_pos_reg;
    logic signed [SW-1:0] sum_b;
    logic signed [SW-1:0] sum_g;
    logic signed [SW-1:0] sum_r;

    assign o_ready   = !o_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || o_ready;
    assign issue     = blk_valid && s1_ready;
    // release the block once its last pixel enters the multiply stage
    assign blk_ready = s1_ready && (pos_reg == y2r_pkg::POS_BOTTOM_RIGHT);

    always_comb
    begin
        yd     = $signed({1'b0, blk.luma[pos_reg]}) - y2r_pkg::LUMA_BIAS;
        y_next = yd * y2r_pkg::K_LUMA;
    end

    always_comb
    begin
        sum_b = SW'(s1_y_reg) + SW'(s1_b_reg);
        sum_g = SW'(s1_y_reg) - SW'(s1_g_reg);
        sum_r = SW'(s1_y_reg) + SW'(s1_r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= y2r_pkg::POS_TOP_LEFT;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (issue)
                pos_reg <= pos_reg + 2'd1;
            if (s1_ready)
                s1_valid_reg <= issue;
            if (o_ready)
                o_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_pos_reg <= pos_reg;
            s1_y_reg   <= y_next;
            s1_b_reg   <= blk.b_term;
            s1_g_reg   <= blk.g_term;
            s1_r_reg   <= blk.r_term;
        end
        if (o_ready && s1_valid_reg)
        begin
            o_pos_reg   <= s1_pos_reg;
            o_blue_reg  <= y2r_pkg::clamp_px(sum_b);
            o_green_reg <= y2r_pkg::clamp_px(sum_g);
            o_red_reg   <= y2r_pkg::clamp_px(sum_r);
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = {(output_format == y2r_pkg::FMT_BGRA32) ? y2r_pkg::ALPHA_OPAQUE : 8'd0,
                        o_red_reg, o_green_reg, o_blue_reg};
    assign out_user  = o_pos_reg;
    assign out_last  = (o_pos_reg == y2r_pkg::POS_BOTTOM_RIGHT);

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;

    // one 2x2 block as it travels on s_axis_tdata, luma[0] in the lowest byte
    typedef struct packed {
        logic [7:0]      chroma_red;
        logic [7:0]      chroma_blue;
        logic [3:0][7:0] luma;
    } block_t;

    typedef struct {
        logic [7:0]          blue;
        logic [7:0]          green;
        logic [7:0]          red;
        logic [7:0]          alpha;
        y2r_pkg::pix_pos_t   pos;
        logic                is_last;
    } pixel_t;

    class pixel_scoreboard;
        y2r_pkg::out_fmt_t fmt;
        pixel_t            expected_q[$];
        int unsigned       mismatches;
        int unsigned       pixels_checked;
        int unsigned       blocks_per_fmt[2];

        function new();
            fmt = y2r_pkg::FMT_BGRA32;
            mismatches = 0;
            pixels_checked = 0;
            blocks_per_fmt[0] = 0;
            blocks_per_fmt[1] = 0;
        endfunction

        // floor divide by 2^16, then saturate to a byte
        static function logic [7:0] floor_clamp(int acc);
            int t;
            t = acc >>> y2r_pkg::FracBits;
            if (t < 0)
                return 8'd0;
            if (t > 255)
                return y2r_pkg::PIX_MAX;
            return t[7:0];
        endfunction

        function void note_block(block_t b);
            int     cb_off;
            int     cr_off;
            int     b_term;
            int     g_term;
            int     r_term;
            int     y_term;
            pixel_t px;
            cb_off = int'(b.chroma_blue) - int'(y2r_pkg::CHROMA_BIAS);
            cr_off = int'(b.chroma_red) - int'(y2r_pkg::CHROMA_BIAS);
            b_term = cb_off * int'(y2r_pkg::K_CB_BLUE);
            g_term = cr_off * int'(y2r_pkg::K_CR_GREEN) + cb_off * int'(y2r_pkg::K_CB_GREEN);
            r_term = cr_off * int'(y2r_pkg::K_CR_RED);
            for (int k = 0; k < 4; k++) begin
                y_term     = (int'(b.luma[k]) - int'(y2r_pkg::LUMA_BIAS))
                             * int'(y2r_pkg::K_LUMA);
                px.blue    = floor_clamp(y_term + b_term);
                px.green   = floor_clamp(y_term - g_term);
                px.red     = floor_clamp(y_term + r_term);
                px.alpha   = (fmt == y2r_pkg::FMT_BGRA32) ? y2r_pkg::ALPHA_OPAQUE : 8'd0;
                px.pos     = y2r_pkg::pix_pos_t'(k);
                px.is_last = (k == 3);
                expected_q.push_back(px);
            end
            blocks_per_fmt[fmt]++;
        endfunction

        function void check_pixel(logic [31:0] data, logic [1:0] user, logic tlast);
            pixel_t exp_px;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel data=%h pos=%0d last=%b",
                             $realtime, data, user, tlast);
                return;
            end
            exp_px = expected_q.pop_front();
            pixels_checked++;
            if (data[7:0] !== exp_px.blue || data[15:8] !== exp_px.green ||
                data[23:16] !== exp_px.red || data[31:24] !== exp_px.alpha ||
                user !== exp_px.pos || tlast !== exp_px.is_last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: pixel mismatch expected b=%h g=%h r=%h a=%h pos=%0d last=%b",
                           $realtime, exp_px.blue, exp_px.green, exp_px.red,
                           exp_px.alpha, exp_px.pos, exp_px.is_last);
                    $display(", got b=%h g=%h r=%h a=%h pos=%0d last=%b",
                             data[7:0], data[15:8], data[23:16], data[31:24], user, tlast);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int unsigned send_idle_pct = 25;
    int unsigned sink_stall_pct = 74;
    int unsigned cycle_count = 0;

    pixel_scoreboard sb = new();

    yuv420_to_rgb_block_converter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    function automatic block_t make_block(logic [7:0] tl, logic [7:0] tr, logic [7:0] bl,
                                          logic [7:0] br, logic [7:0] cb, logic [7:0] cr);
        block_t b;
        b.luma[0] = tl;
        b.luma[1] = tr;
        b.luma[2] = bl;
        b.luma[3] = br;
        b.chroma_blue = cb;
        b.chroma_red = cr;
        return b;
    endfunction

    // mostly uniform, with a bias toward the clamp and bias points
    function automatic logic [7:0] rand_byte();
        if ($urandom_range(4) != 0)
            return 8'($urandom_range(255));
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd128;
            4: return 8'd235;
            default: return 8'd240;
        endcase
    endfunction

    task automatic send_block(input block_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_block(b);
        @(negedge clk);
    endtask

    // hold off the sender until every pending pixel has come out
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_format(input y2r_pkg::out_fmt_t f);
        drain_pixels();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= f;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.fmt = f;
    endtask

    task automatic run_random(input int unsigned n, input bit pause_midway);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (pause_midway && i == n / 2)
                drain_pixels();
            send_block(make_block(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                                  rand_byte(), rand_byte()));
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed blocks under the reset format (32-bit BGRA)
        send_block(make_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_block(make_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_block(make_block(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128));
        send_block(make_block(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128));
        send_block(make_block(8'd0, 8'd85, 8'd170, 8'd255, 8'd128, 8'd128));
        send_block(make_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd128));
        send_block(make_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd128));
        send_block(make_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd0));
        // full-scale Cr exposes a wrong red gain
        send_block(make_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd255));
        send_block(make_block(8'd16, 8'd235, 8'd16, 8'd235, 8'd0, 8'd255));
        send_block(make_block(8'd235, 8'd16, 8'd235, 8'd16, 8'd255, 8'd0));
        send_block(make_block(8'd81, 8'd145, 8'd41, 8'd210, 8'd90, 8'd240));
        send_block(make_block(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
        send_block(make_block(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_block(make_block(8'd17, 8'd15, 8'd16, 8'd255, 8'd127, 8'd129));

        write_format(y2r_pkg::FMT_BGR24);
        run_random(60, 1'b1);

        send_idle_pct  = 74;
        sink_stall_pct = 25;
        write_format(y2r_pkg::FMT_BGRA32);
        run_random(70, 1'b0);

        send_idle_pct  = 0;
        sink_stall_pct = 0;
        write_format(y2r_pkg::FMT_BGR24);
        run_random(35, 1'b0);
        write_format(y2r_pkg::FMT_BGRA32);
        run_random(35, 1'b0);

        drain_pixels();
        repeat (20) @(negedge clk);

        $display("coverage: %0d blocks in BGR24, %0d blocks in BGRA32, %0d pixels checked",
                 sb.blocks_per_fmt[y2r_pkg::FMT_BGR24], sb.blocks_per_fmt[y2r_pkg::FMT_BGRA32],
                 sb.pixels_checked);
        $display("handshake: sender-idle, sink-stall and full-rate phases, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
